/* hdl/tclu_pkg.sv */
// ----------------------------------------------------------------------------
// Tag color table package
// Shared types, codes and default sizes for the tag color lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package tclu_pkg;

    // Default table geometry.
    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int KEY_BITS_DEF      = 96;

    // Field widths of the stream beats.
    localparam int KEY_HIGH_W  = 32;
    localparam int KEY_LOW_W   = 64;
    localparam int FULL_KEY_W  = KEY_HIGH_W + KEY_LOW_W;
    localparam int COLOR_W     = 24;
    localparam int STATUS_W    = 2;
    localparam int OUT_IDX_W   = 7;
    localparam int OUT_CNT_W   = 8;
    localparam int IN_DATA_W   = 120;
    localparam int OUT_DATA_W  = 40;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEW   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Control part of the search token that walks down the row of cells.
    typedef struct packed {
        logic valid;
        logic hit;
    } t_token;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

/* hdl/tclu_cell.sv */
// ----------------------------------------------------------------------------
// Tag color table cell
// Holds one table entry and compares it against the search token passing by.
// ----------------------------------------------------------------------------
`default_nettype none

module tclu_cell #(
    parameter int KEY_BITS   = tclu_pkg::KEY_BITS_DEF,
    parameter int IDX_W      = 7,
    parameter int CNT_W      = 8,
    parameter int CELL_INDEX = 0
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire [KEY_BITS-1:0]          i_query_key,
    input  wire [CNT_W-1:0]             i_count,
    input  wire                         i_wr_en,
    input  wire [KEY_BITS-1:0]          i_wr_key,
    input  wire [tclu_pkg::COLOR_W-1:0] i_wr_color,
    input  wire tclu_pkg::t_token       i_tok,
    input  wire [IDX_W-1:0]             i_tok_idx,
    input  wire [tclu_pkg::COLOR_W-1:0] i_tok_color,
    output tclu_pkg::t_token            o_tok,
    output logic [IDX_W-1:0]            o_tok_idx,
    output logic [tclu_pkg::COLOR_W-1:0] o_tok_color
);

    logic [KEY_BITS-1:0]          r_key;
    logic [tclu_pkg::COLOR_W-1:0] r_color;
    tclu_pkg::t_token             r_tok;
    logic [IDX_W-1:0]             r_tok_idx;
    logic [tclu_pkg::COLOR_W-1:0] r_tok_color;
    logic                         filled;
    logic                         match;

    // Only entries below the fill count hold a key.
    assign filled = CNT_W'(CELL_INDEX) < i_count;
    assign match  = i_tok.valid && !i_tok.hit && filled && (r_key == i_query_key);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key   <= i_wr_key;
            r_color <= i_wr_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_tok.hit   <= i_tok.hit || match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (match) begin
            r_tok_idx   <= IDX_W'(CELL_INDEX);
            r_tok_color <= r_color;
        end else begin
            r_tok_idx   <= i_tok_idx;
            r_tok_color <= i_tok_color;
        end
    end

    assign o_tok       = r_tok;
    assign o_tok_idx   = r_tok_idx;
    assign o_tok_color = r_tok_color;

endmodule

`default_nettype wire

/* hdl/tag_color_lookup_or_insert_core.sv */
// ----------------------------------------------------------------------------
// Tag color lookup or insert core
// Associative tag-to-color table, searched by a token that walks a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one beat per tag: key_high, key_low and a candidate
//   color. The table is searched in insertion order; on a hit the stored color
//   and index come back with status found, on a miss with room the key and the
//   candidate color are appended and returned with status new, and on a full
//   table a full status is returned with zero color and index. The master
//   stream returns one beat per tag, with the status in tuser.
//   Timing: a search token moves one cell per cycle through TABLE_ENTRIES
//   cells; an item passes through the query registers, the row of cells, the
//   hit register and the output register, and a new item is accepted once
//   the previous result has been placed in the output register.
//   A stalled receiver holds the result beat; one further item may be taken
//   and searched meanwhile, and its result waits until the output frees up.
//   Reset empties the table by clearing the fill count; stored keys are not
//   cleared and are never compared before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module tag_color_lookup_or_insert_core #(
    parameter int TABLE_ENTRIES = tclu_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = tclu_pkg::KEY_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // key_high[31:0], key_low[95:32], fresh_color[119:96]
    input  wire [tclu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // color_rgb[23:0], entry_index[30:24], filled_count[38:31], zero pad[39]
    output logic [tclu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [tclu_pkg::STATUS_W-1:0]    m_axis_tuser
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CW    = tclu_pkg::COLOR_W;

    tclu_pkg::t_state r_state, n_state;

    logic [KEY_BITS-1:0] r_query_key;
    logic [CW-1:0]       r_query_color;
    logic [CNT_W-1:0]    r_count;
    logic                r_inject;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [CW-1:0]       r_hit_color;

    logic                          r_m_valid;
    logic [tclu_pkg::STATUS_W-1:0] r_m_status;
    logic [CW-1:0]                 r_m_color;
    logic [tclu_pkg::OUT_IDX_W-1:0] r_m_idx;
    logic [tclu_pkg::OUT_CNT_W-1:0] r_m_count;

    logic accept;
    logic load;
    logic room;
    logic insert;

    tclu_pkg::t_token tok      [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] tok_idx  [TABLE_ENTRIES+1];
    logic [CW-1:0]    tok_color[TABLE_ENTRIES+1];

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tclu_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = tclu_pkg::ST_SEARCH;
                end
            end
            tclu_pkg::ST_SEARCH: begin
                if (tok[TABLE_ENTRIES].valid) begin
                    n_state = tclu_pkg::ST_RESULT;
                end
            end
            tclu_pkg::ST_RESULT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = tclu_pkg::ST_IDLE;
                end
            end
            default: n_state = tclu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        load          = 1'b0;
        case (r_state)
            tclu_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            tclu_pkg::ST_RESULT: load = !r_m_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
                load          = 1'b0;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;
    assign room   = r_count < CNT_W'(TABLE_ENTRIES);
    assign insert = load && !r_hit && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tclu_pkg::ST_IDLE;
            r_inject <= 1'b0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_inject <= accept;
            if (insert) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // The full key is {key_high, key_low}; only its low KEY_BITS bits count.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_query_key   <= KEY_BITS'({s_axis_tdata[31:0], s_axis_tdata[95:32]});
            r_query_color <= s_axis_tdata[119:96];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tclu_pkg::ST_SEARCH && tok[TABLE_ENTRIES].valid) begin
            r_hit       <= tok[TABLE_ENTRIES].hit;
            r_hit_idx   <= tok_idx[TABLE_ENTRIES];
            r_hit_color <= tok_color[TABLE_ENTRIES];
        end
    end

    // ---------------- row of cells ----------------
    assign tok[0].valid = r_inject;
    assign tok[0].hit   = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_color[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        tclu_cell #(
            .KEY_BITS   (KEY_BITS),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_query_key (r_query_key),
            .i_count     (r_count),
            .i_wr_en     (insert && (r_count == CNT_W'(g))),
            .i_wr_key    (r_query_key),
            .i_wr_color  (r_query_color),
            .i_tok       (tok[g]),
            .i_tok_idx   (tok_idx[g]),
            .i_tok_color (tok_color[g]),
            .o_tok       (tok[g+1]),
            .o_tok_idx   (tok_idx[g+1]),
            .o_tok_color (tok_color[g+1])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_hit) begin
                r_m_status <= tclu_pkg::STATUS_FOUND;
                r_m_color  <= r_hit_color;
                r_m_idx    <= tclu_pkg::OUT_IDX_W'(r_hit_idx);
                r_m_count  <= tclu_pkg::OUT_CNT_W'(r_count);
            end else if (room) begin
                r_m_status <= tclu_pkg::STATUS_NEW;
                r_m_color  <= r_query_color;
                r_m_idx    <= tclu_pkg::OUT_IDX_W'(r_count);
                r_m_count  <= tclu_pkg::OUT_CNT_W'(r_count + 1'b1);
            end else begin
                r_m_status <= tclu_pkg::STATUS_FULL;
                r_m_color  <= '0;
                r_m_idx    <= '0;
                r_m_count  <= tclu_pkg::OUT_CNT_W'(r_count);
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_count, r_m_idx, r_m_color};
    assign m_axis_tuser  = r_m_status;

endmodule

`default_nettype wire

/* hdl/tclu_checker.sv */
// ----------------------------------------------------------------------------
// Tag color table port checker
// Checks result beats of the tag color lookup core as seen on its ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tclu_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [tclu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire [tclu_pkg::STATUS_W-1:0]     m_axis_tuser
);

    // No result beat is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid after reset");

    // A full table gives zero color and zero index.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == tclu_pkg::STATUS_FULL
        |-> m_axis_tdata[30:0] == '0)
        else $error("full status with nonzero color or index");

    // A new entry always leaves at least one entry filled, past its own index.
    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == tclu_pkg::STATUS_NEW
        |-> m_axis_tdata[38:31] != 8'd0 && m_axis_tdata[38:31] > {1'b0, m_axis_tdata[30:24]})
        else $error("inserted entry with zero fill count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind tag_color_lookup_or_insert_core tclu_checker u_tclu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
